>>> rtl/core/ri2a_pkg.sv
// ----------------------------------------------------------------------------
// ri2a_pkg: shared types and constants for the radix integer-to-ASCII block
// Holds the request and result payload structs, the controller/datapath
// command and status structs, and the fixed field widths.
// ----------------------------------------------------------------------------
package ri2a_pkg;

    // Field widths fixed by the payload format.
    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;

    // Default depth of the digit store.
    localparam int MAX_DIGITS  = 32;

    // Quotient bits resolved per cycle by the divider.
    localparam int STEP_BITS   = 8;

    // Radix saturation limits.
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    // Digit to character mapping.
    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = CHAR_W'(55);
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = RADIX_W'(10);

    // Incoming request.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
    } t_in_item;

    // One emitted character.
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request
        logic div_step;  // run one divider step
        logic rd;        // read the digit store at the emit pointer
        logic out_load;  // move the read digit into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_chunk;  // this divider step finishes a division
        logic quot_zero;   // quotient of the finishing division is zero
        logic cnt_full;    // digit store is about to be full
        logic ptr_zero;    // emit pointer is at the least significant digit
        logic out_free;    // output register can take a new character
    } t_status;

endpackage

>>> rtl/core/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: unsigned integer to ASCII digits in radix 2..36
// Converts one 32-bit value per request into its digit characters,
// most significant first, with the final character flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries a value and
//   a radix; radix codes below 2 act as 2 and codes above 36 act as 36.
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries one
//   ASCII character per digit, '0'..'9' then 'A'..'Z', last set on the least
//   significant one. A zero value gives the single character '0'.
//   Timing: each digit costs one division (8 quotient bits per cycle over
//   the 32-bit value); once all divisions are done, each digit is read from
//   the digit store and loaded into the output register. o_in_stall is high
//   from acceptance until the final character is loaded into the output
//   register, so the next request may be taken while that character still
//   waits. While the receiver stalls, the current character holds and
//   emission pauses. Reset returns to idle and drops any request in
//   progress.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
    parameter int MAX_DIGITS = ri2a_pkg::MAX_DIGITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ri2a_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ri2a_pkg::t_out_item o_out_item
);

    ri2a_pkg::t_cmd    cmd;
    ri2a_pkg::t_status status;

    // Sequencer.
    ri2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Divider, digit store and output register.
    ri2a_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/core/ri2a_ctrl.sv
// ----------------------------------------------------------------------------
// ri2a_ctrl: sequencer for the radix integer-to-ASCII block
// Steps through request capture, repeated division and reverse-order
// character output, driving the datapath through command signals.
// ----------------------------------------------------------------------------
module ri2a_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ri2a_pkg::t_status i_status,
    output ri2a_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DIV     = 2'd1;
    localparam logic [1:0] S_EMIT_RD = 2'd2;
    localparam logic [1:0] S_EMIT_WR = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last_chunk && (i_status.quot_zero || i_status.cnt_full)) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_status.ptr_zero ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // New requests are taken only between conversions.
    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/ri2a_dp.sv
// ----------------------------------------------------------------------------
// ri2a_dp: datapath for the radix integer-to-ASCII block
// Holds a multi-cycle divider that resolves a few quotient bits per cycle,
// the digit store, and the output register of the result channel.
// ----------------------------------------------------------------------------
module ri2a_dp #(
    parameter int MAX_DIGITS = ri2a_pkg::MAX_DIGITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ri2a_pkg::t_in_item  i_in_item,
    input  ri2a_pkg::t_cmd      i_cmd,
    output ri2a_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ri2a_pkg::t_out_item o_out_item
);

    localparam int VW     = ri2a_pkg::VALUE_WIDTH;
    localparam int RW     = ri2a_pkg::RADIX_W;
    localparam int CW     = ri2a_pkg::CHAR_W;
    localparam int SB     = ri2a_pkg::STEP_BITS;
    localparam int NCHUNK = (VW + SB - 1) / SB;
    localparam int PW     = NCHUNK * SB;
    localparam int SW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);

    localparam logic [SW-1:0] STEP_LAST = SW'(NCHUNK - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_DIGITS - 1);

    // Map a digit to its ASCII character.
    function automatic logic [CW-1:0] digit_to_ascii(input logic [RW-1:0] d);
        logic [CW-1:0] dx;
        dx = CW'(d);
        if (d < ri2a_pkg::DECIMAL_LIMIT) begin
            return ri2a_pkg::ASCII_ZERO + dx;
        end
        return dx + ri2a_pkg::LETTER_OFFSET;
    endfunction

    logic [PW-1:0]   r_num;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_radix;
    logic [SW-1:0]   r_step;
    logic [AW-1:0]   r_cnt;
    logic [AW-1:0]   r_ptr;
    logic [CW-1:0]   r_rd_data;
    logic            r_out_valid;
    ri2a_pkg::t_out_item r_out_item;

    logic [CW-1:0]   r_mem [MAX_DIGITS];

    logic [PW-1:0]   n_num;
    logic [RW-1:0]   n_rem;
    logic [RW-1:0]   n_radix;
    logic            div_last;
    logic            out_free;

    // Radix saturated into the meaningful range.
    always_comb begin
        priority if (i_in_item.radix < ri2a_pkg::RADIX_MIN) begin
            n_radix = ri2a_pkg::RADIX_MIN;
        end else if (i_in_item.radix > ri2a_pkg::RADIX_MAX) begin
            n_radix = ri2a_pkg::RADIX_MAX;
        end else begin
            n_radix = i_in_item.radix;
        end
    end

    // One divider step: restoring division over the top SB bits of the dividend.
    always_comb begin
        logic [RW:0]   rem_x;
        logic [RW-1:0] rem;
        logic [SB-1:0] top;
        logic [SB-1:0] q;
        rem = r_rem;
        top = r_num[PW-1 -: SB];
        q   = '0;
        for (int i = SB - 1; i >= 0; i--) begin
            rem_x = {rem, top[i]};
            if (rem_x >= {1'b0, r_radix}) begin
                rem_x = rem_x - {1'b0, r_radix};
                q[i]  = 1'b1;
            end
            rem = rem_x[RW-1:0];
        end
        n_rem = rem;
        n_num = (r_num << SB) | PW'(q);
    end

    assign div_last = (r_step == STEP_LAST);
    assign out_free = !r_out_valid || !i_out_stall;

    // Divider and digit bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_cnt  <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            if (div_last) begin
                r_step <= '0;
                r_cnt  <= r_cnt + AW'(1);
                r_ptr  <= r_cnt;
            end else begin
                r_step <= r_step + SW'(1);
            end
        end else if (i_cmd.out_load) begin
            r_ptr <= r_ptr - AW'(1);
        end
    end

    // Dividend, remainder and radix payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= PW'(i_in_item.value);
            r_rem   <= '0;
            r_radix <= n_radix;
        end else if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= div_last ? '0 : n_rem;
        end
    end

    // Digit store: written as each division finishes, read when emitting.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && div_last) begin
            r_mem[r_cnt] <= digit_to_ascii(n_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    // Output register of the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.digit_char <= r_rd_data;
            r_out_item.last       <= (r_ptr == '0);
        end
    end

    assign o_status.last_chunk = div_last;
    assign o_status.quot_zero  = (n_num == '0);
    assign o_status.cnt_full   = (r_cnt == ADDR_LAST);
    assign o_status.ptr_zero   = (r_ptr == '0);
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
